@@ sv/sshc_pkg.sv @@
// shared types, constants and signature tables for the stream signature and header check
// no dependencies
package sshc_pkg;

	localparam int HIST_DEPTH = 9;
	localparam int SIG_COUNT  = 4;
	localparam int SIG_MAX    = 10;
	localparam int FILL_W     = 4;
	localparam int DIM_W      = 16;
	localparam int SMALL_W    = 8;
	localparam int CAP_W      = 42;
	localparam int FBC_W      = 37;
	localparam int VERDICT_W  = 3;
	localparam int IDX_W      = 3;
	localparam int MUL_A_W    = 40;
	localparam int MUL_B_W    = 16;
	localparam int PROD_W     = 45;

	typedef logic [7:0] byte_t;
	typedef byte_t [HIST_DEPTH-1:0] hist_t;

	typedef enum logic [VERDICT_W-1:0] {
		V_OK        = 3'd0,
		V_EMPTY     = 3'd1,
		V_SIGNATURE = 3'd2,
		V_MALFORMED = 3'd3,
		V_CODEC     = 3'd4,
		V_OUT_SMALL = 3'd5
	} verdict_t;

	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
	localparam logic [IDX_W-1:0] REG_CHANNEL_COUNT = 3'd2;
	localparam logic [IDX_W-1:0] REG_SAMPLE_BITS   = 3'd3;
	localparam logic [IDX_W-1:0] REG_CODEC_CODE    = 3'd4;
	localparam logic [IDX_W-1:0] REG_STORE_SPACE   = 3'd5;

	localparam logic [SMALL_W-1:0] CODEC_RAW     = 8'd0;
	localparam logic [SMALL_W-1:0] CODEC_MAX     = 8'd4;
	localparam logic [SMALL_W-1:0] BITS_8        = 8'd8;
	localparam logic [SMALL_W-1:0] BITS_16       = 8'd16;
	localparam logic [SMALL_W-1:0] CHANNEL_RESET = 8'd3;
	localparam logic [SMALL_W-1:0] BITS_RESET    = 8'd8;

	typedef struct packed {
		logic [DIM_W-1:0]   frame_width;
		logic [DIM_W-1:0]   frame_height;
		logic [SMALL_W-1:0] channel_count;
		logic [SMALL_W-1:0] sample_bits;
		logic [SMALL_W-1:0] codec_code;
		logic [CAP_W-1:0]   store_space;
	} cfg_t;

	localparam int SIG_LEN [SIG_COUNT] = '{8, 10, 8, 4};

	localparam byte_t SIG_BYTES [SIG_COUNT][SIG_MAX] = '{
		'{8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00},
		'{8'h6D, 8'h6F, 8'h6F, 8'h76, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF},
		'{8'h80, 8'h60, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h00, 8'h00, 8'h01, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	// signature s ends at the current byte, all of it inside the stream
	function automatic logic sig_hit(input int s, input byte_t cur, input hist_t hist,
			input logic [FILL_W-1:0] fill);
		logic hit;
		int   len;
		len = SIG_LEN[s];
		hit = ((int'(fill) + 1) >= len) && (cur == SIG_BYTES[s][len-1]);
		for (int k = 1; k < SIG_MAX; k++) begin
			if (k < len) begin
				if (hist[k-1] != SIG_BYTES[s][len-1-k])
					hit = 1'b0;
			end
		end
		return hit;
	endfunction

endpackage

@@ sv/sshc_in_if.sv @@
// input request channel: one stream byte and/or end marker per request
// depends on nothing
interface sshc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       end_of_stream;

	modport source(output valid, data_byte, has_byte, end_of_stream, input ready);
	modport sink(input valid, data_byte, has_byte, end_of_stream, output ready);
endinterface

@@ sv/sshc_out_if.sv @@
// result channel: verdict and frame byte count
// depends on sshc_pkg
interface sshc_out_if;
	import sshc_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [VERDICT_W-1:0] verdict;
	logic [FBC_W-1:0]     frame_byte_count;

	modport source(output valid, verdict, frame_byte_count, input ready);
	modport sink(input valid, verdict, frame_byte_count, output ready);
endinterface

@@ sv/sshc_match.sv @@
// byte history, fill and length counters and four-way signature compare
// depends on sshc_pkg
module sshc_match #(
	parameter int COUNT_WIDTH = 42
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   take,
	input  sshc_pkg::byte_t        data,
	input  logic                   clear,
	output logic [COUNT_WIDTH-1:0] total,
	output logic                   seen
);
	import sshc_pkg::*;

	hist_t                   hist_q;
	logic [FILL_W-1:0]       fill_q;
	logic [COUNT_WIDTH-1:0]  total_q;
	logic                    seen_q;
	logic [SIG_COUNT-1:0]    hits;

	always_comb begin
		for (int s = 0; s < SIG_COUNT; s++)
			hits[s] = sig_hit(s, data, hist_q, fill_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			total_q <= '0;
			seen_q  <= 1'b0;
		end else if (clear) begin
			fill_q  <= '0;
			total_q <= '0;
			seen_q  <= 1'b0;
		end else if (take) begin
			seen_q <= seen_q | (|hits);
			if (fill_q < FILL_W'(HIST_DEPTH))
				fill_q <= fill_q + 1'b1;
			if (total_q != '1)
				total_q <= total_q + 1'b1;
		end
	end

	// newest byte at entry 0
	always_ff @(posedge clk) begin
		if (take)
			hist_q <= {hist_q[HIST_DEPTH-2:0], data};
	end

	assign total = total_q;
	assign seen  = seen_q;

endmodule

@@ sv/sshc_judge.sv @@
// end-of-stream sequencer: shared multiplier builds the frame size, then the verdict
// depends on sshc_pkg, sshc_out_if
module sshc_judge #(
	parameter int COUNT_WIDTH   = 42,
	parameter int MAX_DIMENSION = 16384
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  sshc_pkg::cfg_t         cfg,
	input  logic [COUNT_WIDTH-1:0] total,
	input  logic                   seen,
	output logic                   idle,
	output logic                   clear,
	sshc_out_if.source             res
);
	import sshc_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_MUL_H  = 5'b00010,
		S_MUL_C  = 5'b00100,
		S_MUL_S  = 5'b01000,
		S_DECIDE = 5'b10000
	} state_t;

	localparam int CMP_W = (COUNT_WIDTH > PROD_W) ? COUNT_WIDTH : PROD_W;
	localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(MAX_DIMENSION);

	state_t                       state_q;
	logic [PROD_W-1:0]            prod_q;
	logic [MUL_B_W-1:0]           mul_b;
	logic [MUL_A_W+MUL_B_W-1:0]   mul_full;
	logic                         advance;
	logic                         dim_bad;
	logic                         raw_short;
	logic                         bits_bad;
	logic                         cap_short;
	verdict_t                     verdict_d;
	logic                         valid_q;
	logic [VERDICT_W-1:0]         verdict_q;
	logic [FBC_W-1:0]             count_q;

	// operand b of the shared multiplier per step
	always_comb begin
		unique case (state_q)
			S_MUL_H: mul_b = cfg.frame_height;
			S_MUL_C: mul_b = MUL_B_W'(cfg.channel_count);
			S_MUL_S: mul_b = MUL_B_W'(cfg.sample_bits[7:3]);
			default: mul_b = '0;
		endcase
	end

	assign mul_full = prod_q[MUL_A_W-1:0] * mul_b;

	assign advance = !valid_q || res.ready;
	assign idle    = (state_q == S_IDLE);
	assign clear   = (state_q == S_DECIDE) && advance;

	assign dim_bad = (cfg.frame_width == '0) || (cfg.frame_height == '0) ||
		(cfg.channel_count == '0) || (cfg.frame_width > MAX_DIM) ||
		(cfg.frame_height > MAX_DIM);
	assign raw_short = (cfg.codec_code == CODEC_RAW) &&
		(CMP_W'(total) < CMP_W'(prod_q));
	assign bits_bad  = (cfg.sample_bits != BITS_8) && (cfg.sample_bits != BITS_16);
	assign cap_short = PROD_W'(cfg.store_space) < prod_q;

	always_comb begin
		if (total == '0)
			verdict_d = V_EMPTY;
		else if (seen)
			verdict_d = V_SIGNATURE;
		else if (dim_bad || raw_short || bits_bad)
			verdict_d = V_MALFORMED;
		else if (cfg.codec_code > CODEC_MAX)
			verdict_d = V_CODEC;
		else if (cap_short)
			verdict_d = V_OUT_SMALL;
		else
			verdict_d = V_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:   if (start) state_q <= S_MUL_H;
				S_MUL_H:  state_q <= S_MUL_C;
				S_MUL_C:  state_q <= S_MUL_S;
				S_MUL_S:  state_q <= S_DECIDE;
				S_DECIDE: if (advance) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	// width * height * channels * (bits / 8), one factor per cycle
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE)
			prod_q <= PROD_W'(cfg.frame_width);
		else if (state_q != S_DECIDE)
			prod_q <= mul_full[PROD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clear) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clear) begin
			verdict_q <= verdict_d;
			count_q   <= (verdict_d == V_OK) ? prod_q[FBC_W-1:0] : '0;
		end
	end

	assign res.valid            = valid_q;
	assign res.verdict          = verdict_q;
	assign res.frame_byte_count = count_q;

endmodule

@@ sv/stream_signature_and_header_check.sv @@
// top level: configuration registers, byte matcher and end-of-stream judge
// depends on sshc_pkg, sshc_in_if, sshc_out_if, sshc_match, sshc_judge
//
// channel  dir  payload                                   handshake
// stream   in   data_byte, has_byte, end_of_stream        valid/ready
// result   out  verdict, frame_byte_count                 valid/ready
// cfg      in   cfg_index, cfg_wdata                      cfg_wr_en, no wait
//
// a request without end marker is taken while the judge is idle, so bytes stream at one per cycle while it is idle
// a request with end marker walks the judge through three steps of the shared multiplier
// and a compare step; the result register then frees the input side
// reset clears the stream counters and loads the register defaults
// a stalled result holds the judge in its compare step until the slot frees
module stream_signature_and_header_check #(
	parameter int COUNT_WIDTH   = 42,
	parameter int MAX_DIMENSION = 16384
) (
	input  logic                        clk,
	input  logic                        arst_n,
	sshc_in_if.sink                     stream,
	sshc_out_if.source                  result,
	input  logic                        cfg_wr_en,
	input  logic [sshc_pkg::IDX_W-1:0]  cfg_index,
	input  logic [sshc_pkg::CAP_W-1:0]  cfg_wdata
);
	import sshc_pkg::*;

	cfg_t                   cfg_q;
	logic                   accept;
	logic                   idle;
	logic                   clear;
	logic [COUNT_WIDTH-1:0] total;
	logic                   seen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width   <= '0;
			cfg_q.frame_height  <= '0;
			cfg_q.channel_count <= CHANNEL_RESET;
			cfg_q.sample_bits   <= BITS_RESET;
			cfg_q.codec_code    <= CODEC_RAW;
			cfg_q.store_space   <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:   cfg_q.frame_width   <= cfg_wdata[DIM_W-1:0];
				REG_FRAME_HEIGHT:  cfg_q.frame_height  <= cfg_wdata[DIM_W-1:0];
				REG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_wdata[SMALL_W-1:0];
				REG_SAMPLE_BITS:   cfg_q.sample_bits   <= cfg_wdata[SMALL_W-1:0];
				REG_CODEC_CODE:    cfg_q.codec_code    <= cfg_wdata[SMALL_W-1:0];
				REG_STORE_SPACE:   cfg_q.store_space   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign stream.ready = idle;
	assign accept       = stream.valid && idle;

	sshc_match #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_match (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (accept && stream.has_byte),
		.data   (stream.data_byte),
		.clear  (clear),
		.total  (total),
		.seen   (seen)
	);

	sshc_judge #(
		.COUNT_WIDTH   (COUNT_WIDTH),
		.MAX_DIMENSION (MAX_DIMENSION)
	) u_judge (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && stream.end_of_stream),
		.cfg    (cfg_q),
		.total  (total),
		.seen   (seen),
		.idle   (idle),
		.clear  (clear),
		.res    (result)
	);

	a_busy_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && stream.end_of_stream) |=> !stream.ready)
		else $error("input ready while judging a stream");

	a_ok_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (result.verdict == VERDICT_W'(V_OK))) |->
		(result.frame_byte_count != '0))
		else $error("ok verdict with zero frame size");

	a_fail_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (result.verdict != VERDICT_W'(V_OK))) |->
		(result.frame_byte_count == '0))
		else $error("failed verdict with nonzero frame size");

endmodule
